FILE: rtl/trap_pkg.sv
// Shared types, constants and fixed-point helpers for the trapezoid motion profile core.
// Used by the planner, the sample pipeline and the top level. No dependencies.
`default_nettype none
package trap_pkg;

	localparam int FRAC_BITS = 16;
	localparam int CAP_BITS  = 32;
	localparam int REG_W     = 31;
	localparam int DIV_NUM_W = CAP_BITS + FRAC_BITS;
	localparam int ROOT_W    = DIV_NUM_W / 2;

	typedef logic [CAP_BITS-1:0] q_t;
	typedef logic [REG_W-1:0]    reg_t;

	typedef enum logic [1:0] {
		REG_DISTANCE = 2'd0,
		REG_SPEED    = 2'd1,
		REG_ACCEL    = 2'd2
	} cfg_idx_t;

	typedef enum logic [2:0] {
		SEG_IDLE   = 3'd0,
		SEG_ACCEL  = 3'd1,
		SEG_CRUISE = 3'd2,
		SEG_DECEL  = 3'd3,
		SEG_DONE   = 3'd4
	} seg_t;

	typedef struct packed {
		reg_t accel;
		q_t   accel_time;
		q_t   cruise_end_time;
		q_t   finish_time;
		q_t   peak_speed;
		q_t   accel_end_position;
		q_t   accel_end_speed;
		q_t   cruise_end_position;
		q_t   final_position;
		q_t   final_speed;
	} plan_t;

	// Fixed-point product, truncated, saturating at the word maximum.
	function automatic q_t qmul(input q_t x, input q_t y);
		logic [2*CAP_BITS-1:0] p;
		logic [2*CAP_BITS-1:0] s;
		p = {{CAP_BITS{1'b0}}, x} * {{CAP_BITS{1'b0}}, y};
		s = p >> FRAC_BITS;
		return (|s[2*CAP_BITS-1:CAP_BITS]) ? '1 : s[CAP_BITS-1:0];
	endfunction

	function automatic q_t qadd(input q_t x, input q_t y);
		logic [CAP_BITS:0] s;
		s = {1'b0, x} + {1'b0, y};
		return s[CAP_BITS] ? '1 : s[CAP_BITS-1:0];
	endfunction

	function automatic q_t qsub(input q_t x, input q_t y);
		return (x > y) ? x - y : '0;
	endfunction

	function automatic reg_t sat_out(input q_t x);
		return (|x[CAP_BITS-1:REG_W]) ? '1 : x[REG_W-1:0];
	endfunction

endpackage
`default_nettype wire

FILE: rtl/trap_div.sv
// Iterative restoring divider for fixed-point quotients, one quotient bit per cycle.
// Depends on trap_pkg for widths.
`default_nettype none
module trap_div (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            start,
	input  wire logic [trap_pkg::DIV_NUM_W-1:0]  num,
	input  wire logic [trap_pkg::REG_W-1:0]      den,
	output logic                                 done,
	output trap_pkg::q_t                         quo
);
	import trap_pkg::*;

	localparam int CNT_W = $clog2(DIV_NUM_W);

	logic                 busy_q;
	logic [CNT_W-1:0]     cnt_q;
	logic [REG_W-1:0]     rem_q;
	logic [REG_W-1:0]     den_q;
	logic [DIV_NUM_W-1:0] quo_q;
	logic [REG_W:0]       shifted;
	logic                 fits;

	assign shifted = {rem_q, quo_q[DIV_NUM_W-1]};
	assign fits    = shifted >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done   <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(DIV_NUM_W - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			den_q <= den;
			quo_q <= num;
		end else if (busy_q) begin
			rem_q <= fits ? REG_W'(shifted - {1'b0, den_q}) : shifted[REG_W-1:0];
			quo_q <= {quo_q[DIV_NUM_W-2:0], fits};
		end
	end

	assign quo = (|quo_q[DIV_NUM_W-1:CAP_BITS]) ? '1 : quo_q[CAP_BITS-1:0];

endmodule
`default_nettype wire

FILE: rtl/trap_sqrt.sv
// Digit-by-digit square root of a fixed-point value, one result bit per cycle.
// Depends on trap_pkg for widths.
`default_nettype none
module trap_sqrt (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	input  wire trap_pkg::q_t  x,
	output logic               done,
	output trap_pkg::q_t       root
);
	import trap_pkg::*;

	localparam int CNT_W = $clog2(ROOT_W);
	localparam int REM_W = ROOT_W + 2;

	logic                 busy_q;
	logic [CNT_W-1:0]     cnt_q;
	logic [DIV_NUM_W-1:0] rad_q;
	logic [REM_W-1:0]     rem_q;
	logic [ROOT_W-1:0]    root_q;
	logic [REM_W+1:0]     cur;
	logic [REM_W+1:0]     trial;
	logic                 fits;

	assign cur   = {rem_q, rad_q[DIV_NUM_W-1 -: 2]};
	assign trial = {2'b00, root_q, 2'b01};
	assign fits  = cur >= trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done   <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(ROOT_W - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rad_q  <= {x, {FRAC_BITS{1'b0}}};
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			rad_q  <= rad_q << 2;
			rem_q  <= fits ? REM_W'(cur - trial) : cur[REM_W-1:0];
			root_q <= {root_q[ROOT_W-2:0], fits};
		end
	end

	assign root = {{(CAP_BITS-ROOT_W){1'b0}}, root_q};

endmodule
`default_nettype wire

FILE: rtl/trap_plan.sv
// Configuration registers and the profile planner: a sequencer over one shared
// multiplier, the divider and the square-root unit. Depends on trap_pkg, trap_div, trap_sqrt.
`default_nettype none
module trap_plan (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    cfg_write,
	input  wire logic [1:0]              cfg_index,
	input  wire logic [trap_pkg::REG_W-1:0] cfg_data,
	output logic                         plan_ok,
	output trap_pkg::plan_t              plan
);
	import trap_pkg::*;

	typedef enum logic [3:0] {
		S_START, S_DIV_TA, S_MUL_A, S_MUL_H, S_CMP, S_DIV_CR, S_DIV_Q, S_SQRT,
		S_MUL_V, S_F1, S_F2, S_F3, S_F4, S_F5, S_F6, S_IDLE
	} state_t;

	state_t state_q;
	reg_t   dist_q, speed_q, accel_q;
	reg_t   v_q, a_q;
	q_t     ta_q, cruise_q, t1_q, h_q, p_q, cet_q, ft_q, cep_q, fp_q, fs_q;

	logic                 cfg_hit;
	logic                 div_start, div_done, sq_start, sq_done;
	logic [DIV_NUM_W-1:0] div_num;
	reg_t                 div_den;
	q_t                   div_quo, sq_root;
	q_t                   mul_x, mul_y, mul_r, two_da, d_ext, v_ext, a_ext;
	logic                 has_cruise;

	assign cfg_hit = cfg_write && (cfg_index == REG_DISTANCE || cfg_index == REG_SPEED
		|| cfg_index == REG_ACCEL);

	assign d_ext = {1'b0, dist_q};
	assign v_ext = {1'b0, v_q};
	assign a_ext = {1'b0, a_q};
	assign two_da = qadd(h_q, h_q);
	assign has_cruise = d_ext > two_da;

	always_comb begin
		unique case (state_q)
			S_MUL_H, S_F2: mul_x = t1_q;
			S_F3, S_F5:    mul_x = v_ext;
			default:       mul_x = a_ext;
		endcase
		mul_y = (state_q == S_F3) ? cruise_q : ta_q;
		mul_r = qmul(mul_x, mul_y);
	end

	always_comb begin
		div_start = 1'b0;
		div_num   = {v_ext, {FRAC_BITS{1'b0}}};
		div_den   = a_q;
		if (state_q == S_START) begin
			div_start = !cfg_hit;
			div_num   = {1'b0, (speed_q == '0) ? REG_W'(1) : speed_q, {FRAC_BITS{1'b0}}};
			div_den   = (accel_q == '0) ? REG_W'(1) : accel_q;
		end else if (state_q == S_CMP) begin
			div_start = !cfg_hit;
			if (has_cruise) begin
				div_num = {d_ext - two_da, {FRAC_BITS{1'b0}}};
				div_den = v_q;
			end else begin
				div_num = {d_ext, {FRAC_BITS{1'b0}}};
			end
		end
	end

	assign sq_start = (state_q == S_DIV_Q) && div_done && !cfg_hit;

	trap_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.done   (div_done),
		.quo    (div_quo)
	);

	trap_sqrt u_sqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (sq_start),
		.x      (div_quo),
		.done   (sq_done),
		.root   (sq_root)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_START;
			plan_ok <= 1'b0;
			dist_q  <= '0;
			speed_q <= REG_W'(1 << FRAC_BITS);
			accel_q <= REG_W'(1 << FRAC_BITS);
		end else if (cfg_hit) begin
			// Any register write throws away the plan and starts it over.
			plan_ok <= 1'b0;
			state_q <= S_START;
			unique case (cfg_idx_t'(cfg_index))
				REG_DISTANCE: dist_q  <= cfg_data;
				REG_SPEED:    speed_q <= cfg_data;
				default:      accel_q <= cfg_data;
			endcase
		end else begin
			unique case (state_q)
				S_START: begin
					v_q     <= (speed_q == '0) ? REG_W'(1) : speed_q;
					a_q     <= (accel_q == '0) ? REG_W'(1) : accel_q;
					state_q <= S_DIV_TA;
				end
				S_DIV_TA: if (div_done) begin
					ta_q    <= div_quo;
					state_q <= S_MUL_A;
				end
				S_MUL_A: begin
					t1_q    <= mul_r;
					state_q <= S_MUL_H;
				end
				S_MUL_H: begin
					h_q     <= mul_r >> 1;
					state_q <= S_CMP;
				end
				S_CMP: state_q <= has_cruise ? S_DIV_CR : S_DIV_Q;
				S_DIV_CR: if (div_done) begin
					cruise_q <= div_quo;
					state_q  <= S_F1;
				end
				S_DIV_Q: if (div_done) state_q <= S_SQRT;
				S_SQRT: if (sq_done) begin
					ta_q     <= sq_root;
					cruise_q <= '0;
					state_q  <= S_MUL_V;
				end
				S_MUL_V: begin
					v_q     <= sat_out(mul_r);
					state_q <= S_F1;
				end
				S_F1: begin
					t1_q    <= mul_r;
					cet_q   <= qadd(ta_q, cruise_q);
					state_q <= S_F2;
				end
				S_F2: begin
					h_q     <= mul_r >> 1;
					ft_q    <= qadd(cet_q, ta_q);
					state_q <= S_F3;
				end
				S_F3: begin
					p_q     <= mul_r;
					state_q <= S_F4;
				end
				S_F4: begin
					cep_q   <= qadd(h_q, p_q);
					state_q <= S_F5;
				end
				S_F5: begin
					p_q     <= mul_r;
					state_q <= S_F6;
				end
				S_F6: begin
					fp_q    <= qsub(qadd(cep_q, p_q), h_q);
					fs_q    <= qsub(v_ext, t1_q);
					plan_ok <= 1'b1;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// In the triangular case the peak speed comes from a product that can exceed
	// the register range only at extreme settings; it is held to that range when v_q is stored.
	always_comb begin
		plan.accel               = a_q;
		plan.accel_time          = ta_q;
		plan.cruise_end_time     = cet_q;
		plan.finish_time         = ft_q;
		plan.peak_speed          = v_ext;
		plan.accel_end_position  = h_q;
		plan.accel_end_speed     = t1_q;
		plan.cruise_end_position = cep_q;
		plan.final_position      = fp_q;
		plan.final_speed         = fs_q;
	end

endmodule
`default_nettype wire

FILE: rtl/trap_eval.sv
// Four-stage sample pipeline: segment select, products, second product, combine.
// Depends on trap_pkg for the plan record and fixed-point helpers.
`default_nettype none
module trap_eval (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        plan_ok,
	input  wire trap_pkg::plan_t             plan,
	input  wire logic                        in_valid,
	output logic                             in_ready,
	input  wire trap_pkg::q_t                sample_time,
	output logic                             out_valid,
	input  wire logic                        out_ready,
	output logic [trap_pkg::REG_W-1:0]       position,
	output logic signed [trap_pkg::CAP_BITS-1:0] acceleration,
	output logic [trap_pkg::REG_W-1:0]       velocity,
	output logic [2:0]                       segment
);
	import trap_pkg::*;

	logic v_s1, v_s2, v_s3;
	logic en_s1, en_s2, en_s3, en_s4;
	seg_t seg_s1, seg_s2, seg_s3, seg_d;
	q_t   dt_s1, k_s1, dt_s2, m1_s2, pv_s2, m1_s3, pv_s3, h_s3;
	q_t   pos_d, vel_d, a_ext;
	q_t   dt_d, k_d;

	assign a_ext = {1'b0, plan.accel};

	assign en_s4    = !out_valid || out_ready;
	assign en_s3    = !v_s3 || en_s4;
	assign en_s2    = !v_s2 || en_s3;
	assign en_s1    = !v_s1 || en_s2;
	assign in_ready = plan_ok && en_s1;

	always_comb begin
		dt_d = sample_time;
		k_d  = a_ext;
		priority if (sample_time == '0) begin
			seg_d = SEG_IDLE;
		end else if (sample_time >= plan.finish_time) begin
			seg_d = SEG_DONE;
		end else if (sample_time < plan.accel_time) begin
			seg_d = SEG_ACCEL;
		end else if (sample_time < plan.cruise_end_time) begin
			seg_d = SEG_CRUISE;
			dt_d  = sample_time - plan.accel_time;
			k_d   = plan.accel_end_speed;
		end else begin
			seg_d = SEG_DECEL;
			dt_d  = sample_time - plan.cruise_end_time;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1      <= 1'b0;
			v_s2      <= 1'b0;
			v_s3      <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			if (en_s1) v_s1 <= in_valid && in_ready;
			if (en_s2) v_s2 <= v_s1;
			if (en_s3) v_s3 <= v_s2;
			if (en_s4) out_valid <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1) begin
			seg_s1 <= seg_d;
			dt_s1  <= dt_d;
			k_s1   <= k_d;
		end
		if (en_s2) begin
			seg_s2 <= seg_s1;
			dt_s2  <= dt_s1;
			m1_s2  <= qmul(k_s1, dt_s1);
			pv_s2  <= qmul(plan.peak_speed, dt_s1);
		end
		if (en_s3) begin
			seg_s3 <= seg_s2;
			m1_s3  <= m1_s2;
			pv_s3  <= pv_s2;
			h_s3   <= qmul(m1_s2, dt_s2) >> 1;
		end
	end

	always_comb begin
		unique case (seg_s3)
			SEG_ACCEL: begin
				pos_d = h_s3;
				vel_d = m1_s3;
			end
			SEG_CRUISE: begin
				pos_d = qadd(plan.accel_end_position, m1_s3);
				vel_d = plan.accel_end_speed;
			end
			SEG_DECEL: begin
				pos_d = qsub(qadd(plan.cruise_end_position, pv_s3), h_s3);
				vel_d = qsub(plan.peak_speed, m1_s3);
			end
			SEG_DONE: begin
				pos_d = plan.final_position;
				vel_d = plan.final_speed;
			end
			default: begin
				pos_d = '0;
				vel_d = '0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (en_s4) begin
			position <= sat_out(pos_d);
			velocity <= sat_out(vel_d);
			segment  <= seg_s3;
			unique case (seg_s3)
				SEG_ACCEL:           acceleration <= signed'(a_ext);
				SEG_DECEL, SEG_DONE: acceleration <= signed'(q_t'(0) - a_ext);
				default:             acceleration <= '0;
			endcase
		end
	end

endmodule
`default_nettype wire

FILE: rtl/trapezoid_motion_profile_core.sv
// Top level of the trapezoidal motion profile core: planner plus sample pipeline.
// Depends on trap_pkg, trap_plan and trap_eval.
//
//   Channel   Signals                                        Direction
//   config    cfg_write, cfg_index, cfg_data                 in, no wait
//   sample    in_valid/in_ready, sample_time                 in
//   result    out_valid/out_ready, position, velocity,       out
//             acceleration, segment
//
// A sample beat is taken every cycle while in_ready is high and passes through the
// segment-select, product, second-product and output registers to its result.
// After reset and each register write the planner rebuilds the plan (two 48-step
// divisions, and a 24-step square root for a triangle); in_ready is low meanwhile.
// Each pipeline stage holds its beat under backpressure and fills a bubble
// ahead of it, so a stall drops nothing.
`default_nettype none
module trapezoid_motion_profile_core (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cfg_write,
	input  wire logic [1:0]                      cfg_index,
	input  wire logic [trap_pkg::REG_W-1:0]      cfg_data,
	input  wire logic                            in_valid,
	output logic                                 in_ready,
	input  wire logic [trap_pkg::CAP_BITS-1:0]   sample_time,
	output logic                                 out_valid,
	input  wire logic                            out_ready,
	output logic [trap_pkg::REG_W-1:0]           position,
	output logic [trap_pkg::REG_W-1:0]           velocity,
	output logic signed [trap_pkg::CAP_BITS-1:0] acceleration,
	output logic [2:0]                           segment
);
	import trap_pkg::*;

	logic  plan_ok;
	plan_t plan;

	trap_plan u_plan (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.plan_ok   (plan_ok),
		.plan      (plan)
	);

	trap_eval u_eval (
		.clk          (clk),
		.arst_n       (arst_n),
		.plan_ok      (plan_ok),
		.plan         (plan),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.sample_time  (sample_time),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.position     (position),
		.acceleration (acceleration),
		.velocity     (velocity),
		.segment      (segment)
	);

endmodule
`default_nettype wire

FILE: tb/tb_trapezoid_motion_profile_core.sv
// Testbench for the trapezoid motion profile core: random sample times under random stalls,
// checked against a built-in profile planner. Depends on trap_pkg and the core RTL.
`timescale 1ns / 1ps
module tb_trapezoid_motion_profile_core;
	import trap_pkg::*;

	localparam longint QMAX = 64'hFFFF_FFFF;
	localparam int CYCLE_LIMIT = 3000000;

	logic clk;
	logic arst_n;
	logic cfg_write;
	logic [1:0] cfg_index;
	logic [REG_W-1:0] cfg_data;
	logic in_valid;
	logic in_ready;
	logic [CAP_BITS-1:0] sample_time;
	logic out_valid;
	logic out_ready;
	logic [REG_W-1:0] position;
	logic [REG_W-1:0] velocity;
	logic signed [CAP_BITS-1:0] acceleration;
	logic [2:0] segment;

	typedef struct {
		longint pos;
		longint vel;
		longint acc;
		int seg;
	} motion_t;

	trapezoid_motion_profile_core u_dut (.*);

	// Predictor copy of the registers and the plan.
	longint m_dist, m_vmax, m_amax;
	longint p_ta, p_tce, p_tf, p_vpk, p_xa, p_va, p_xce, p_xf, p_vf;
	bit p_ready;

	logic [CAP_BITS-1:0] sample_q[$];
	motion_t motion_q[$];
	int errors, results, cycles, accepted;
	bit hold_off;

	function automatic longint cap(longint x);
		return x > QMAX ? QMAX : x;
	endfunction

	function automatic longint fmul(longint a, longint b);
		longint unsigned p;
		p = longint'(cap(a)) * longint'(cap(b));
		return cap(longint'(p >> FRAC_BITS));
	endfunction

	function automatic longint fdiv(longint a, longint b);
		if (b == 0) b = 1;
		return cap((cap(a) << FRAC_BITS) / b);
	endfunction

	function automatic longint fsub(longint a, longint b);
		return a > b ? a - b : 0;
	endfunction

	function automatic longint froot(longint x);
		longint v, r;
		v = cap(x) << FRAC_BITS;
		r = 0;
		// Largest r with r*r <= v, by bisection on bits.
		for (int b = 31; b >= 0; b--)
			if ((r | (64'd1 << b)) * (r | (64'd1 << b)) <= v)
				r = r | (64'd1 << b);
		return cap(r);
	endfunction

	function automatic longint travel(longint a, longint t);
		return fmul(fmul(a, t), t) >> 1;
	endfunction

	function automatic void plan_profile();
		longint d, v, a, ta, two_da, cr;
		d = cap(m_dist);
		v = m_vmax == 0 ? 1 : m_vmax;
		a = m_amax == 0 ? 1 : m_amax;
		ta = fdiv(v, a);
		two_da = cap(travel(a, ta) + travel(a, ta));
		cr = 0;
		if (d > two_da) begin
			cr = fdiv(d - two_da, v);
		end else begin
			ta = froot(fdiv(d, a));
			v = fmul(a, ta);
		end
		p_ta = ta;
		p_tce = cap(ta + cr);
		p_tf = cap(p_tce + ta);
		p_vpk = v;
		p_xa = travel(a, ta);
		p_va = fmul(a, ta);
		p_xce = cap(p_xa + fmul(v, cr));
		p_xf = fsub(cap(p_xce + fmul(v, ta)), travel(a, ta));
		p_vf = fsub(v, fmul(a, ta));
		p_ready = 1;
	endfunction

	function automatic motion_t sample_motion(longint t);
		motion_t m;
		longint a, dt;
		a = m_amax == 0 ? 1 : m_amax;
		if (!p_ready) plan_profile();
		if (t == 0) begin
			m = '{0, 0, 0, SEG_IDLE};
		end else if (t >= p_tf) begin
			m = '{p_xf, p_vf, -a, SEG_DONE};
		end else if (t < p_ta) begin
			m = '{travel(a, t), fmul(a, t), a, SEG_ACCEL};
		end else if (t < p_tce) begin
			m = '{cap(p_xa + fmul(p_va, t - p_ta)), p_va, 0, SEG_CRUISE};
		end else begin
			dt = t - p_tce;
			m.pos = fsub(cap(p_xce + fmul(p_vpk, dt)), travel(a, dt));
			m.vel = fsub(p_vpk, fmul(a, dt));
			m.acc = -a;
			m.seg = SEG_DECEL;
		end
		if (m.pos > 64'h7FFF_FFFF) m.pos = 64'h7FFF_FFFF;
		if (m.vel > 64'h7FFF_FFFF) m.vel = 64'h7FFF_FFFF;
		m.acc = m.acc & 64'hFFFF_FFFF;
		return m;
	endfunction

	task automatic report(input string what, input longint got, input longint want);
		errors++;
		$display("result %0d: %s is %0h, expected %0h", results, what, got, want);
	endtask

	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	initial begin
		clk = 0;
		forever #1 clk = ~clk;
	end

	always @(posedge clk) cycles <= cycles + 1;

	// Driver: valid and payload change on the falling edge only.
	int send_gap;
	bit in_acc;
	always @(negedge clk) begin
		if (!arst_n) begin
			in_valid <= 0;
			send_gap <= 0;
		end else begin
			if (in_valid && in_acc) begin
				if (send_gap == 0 && sample_q.size() > 0 && !hold_off) begin
					sample_time <= sample_q.pop_front();
					send_gap <= gap_len();
				end else begin
					in_valid <= 0;
				end
			end else if (!in_valid) begin
				if (send_gap > 0) send_gap <= send_gap - 1;
				else if (sample_q.size() > 0 && !hold_off) begin
					sample_time <= sample_q.pop_front();
					in_valid <= 1;
					send_gap <= gap_len();
				end
			end
			if (in_valid && in_acc && send_gap > 0) send_gap <= send_gap - 1;
		end
	end

	// Sender-side acceptance: predict at the edge the beat is taken.
	always @(posedge clk) begin
		in_acc = in_valid && in_ready;
		if (in_acc) begin
			motion_q.push_back(sample_motion(sample_time));
			accepted++;
		end
	end

	int recv_gap;
	always @(negedge clk) begin
		if (recv_gap > 0) begin
			recv_gap <= recv_gap - 1;
			out_ready <= 0;
		end else begin
			out_ready <= 1;
			if ($urandom_range(0, 3) == 0) recv_gap <= gap_len();
		end
	end

	// Monitor.
	always @(posedge clk) begin
		motion_t m;
		if (arst_n && out_valid && out_ready) begin
			if (motion_q.size() == 0) begin
				report("unexpected beat", 0, 0);
			end else begin
				m = motion_q.pop_front();
				if (position !== m.pos[REG_W-1:0]) report("position", position, m.pos);
				if (velocity !== m.vel[REG_W-1:0]) report("velocity", velocity, m.vel);
				if (acceleration !== m.acc[CAP_BITS-1:0])
					report("acceleration", acceleration, m.acc[CAP_BITS-1:0]);
				if (segment !== m.seg[2:0]) report("segment", segment, m.seg);
			end
			results++;
		end
	end

	initial begin
		wait (cycles >= CYCLE_LIMIT);
		$display("trapezoid_motion_profile_core: mismatch");
		$finish;
	end

	// Checked at rising edges, where the driver's falling-edge updates have settled.
	task automatic drain();
		do @(posedge clk);
		while (sample_q.size() != 0 || in_valid || motion_q.size() != 0);
		repeat (20) @(posedge clk);
	endtask

	// Register write between phases, with the predictor following it.
	task automatic write_reg(input cfg_idx_t idx, input longint val);
		@(negedge clk);
		cfg_write <= 1;
		cfg_index <= idx;
		cfg_data <= val[REG_W-1:0];
		@(negedge clk);
		cfg_write <= 0;
		case (idx)
			REG_DISTANCE: m_dist = val & 64'h7FFF_FFFF;
			REG_SPEED: m_vmax = val & 64'h7FFF_FFFF;
			REG_ACCEL: m_amax = val & 64'h7FFF_FFFF;
			default: ;
		endcase
		if (idx <= REG_ACCEL) plan_profile();
	endtask

	function automatic longint pick_reg(bit zero_ok);
		case ($urandom_range(0, 5))
			0: return zero_ok ? 0 : 1;
			1: return 32'h7FFF_FFFF;
			2: return $urandom_range(1, 32'h7FFF_FFFF);
			3: return $urandom_range(1, 16) << 16;
			4: return $urandom_range(1, 1 << 20);
			default: return $urandom_range(1 << 12, 1 << 22);
		endcase
	endfunction

	// Sample times spread across the profile's segments.
	function automatic logic [31:0] pick_time();
		longint tf;
		tf = p_tf;
		case ($urandom_range(0, 9))
			0: return $urandom();
			1: return 0;
			2: return tf[31:0];
			3: return 32'hFFFF_FFFF;
			default: begin
				if (tf == 0 || tf > 64'hFFFF_FFF0) return $urandom();
				return $urandom_range(0, 32'(tf + 8));
			end
		endcase
	endfunction

	task automatic queue_samples(input int n);
		for (int i = 0; i < n; i++) sample_q.push_back(pick_time());
	endtask

	initial begin
		cfg_write = 0;
		cfg_index = REG_DISTANCE;
		cfg_data = 0;
		sample_time = 0;
		in_valid = 0;
		out_ready = 0;
		recv_gap = 0;
		hold_off = 0;
		errors = 0;
		results = 0;
		cycles = 0;
		accepted = 0;
		m_dist = 0;
		m_vmax = 65536;
		m_amax = 65536;
		p_ready = 0;
		arst_n = 0;
		repeat (10) @(posedge clk);
		@(negedge clk) arst_n = 1;

		// Before any write: zero distance finishes at once.
		sample_q.push_back(0);
		sample_q.push_back(1);
		sample_q.push_back(32'hFFFF_FFFF);
		drain();
		// Index three is not a register and must leave the plan alone.
		@(negedge clk);
		cfg_write <= 1;
		cfg_index <= 2'd3;
		cfg_data <= 31'h1234;
		@(negedge clk) cfg_write <= 0;
		// Directed: trapezoid, triangle, zero limits and extremes.
		write_reg(REG_DISTANCE, 10 << 16);
		write_reg(REG_SPEED, 2 << 16);
		write_reg(REG_ACCEL, 1 << 16);
		sample_q = '{0, 1, 32'h8000, 32'h1_8000, 2 << 16, 32'h4_0000, 6 << 16,
			32'h6_8000, 7 << 16, 8 << 16, 32'hFFFF_FFFF, 32'h8000_0000};
		drain();
		write_reg(REG_DISTANCE, 1 << 16);
		queue_samples(5);
		drain();
		write_reg(REG_SPEED, 0);
		write_reg(REG_ACCEL, 0);
		queue_samples(4);
		drain();
		write_reg(REG_DISTANCE, 32'h7FFF_FFFF);
		write_reg(REG_SPEED, 32'h7FFF_FFFF);
		write_reg(REG_ACCEL, 32'h7FFF_FFFF);
		queue_samples(4);
		drain();

		for (int ph = 0; ph < 35; ph++) begin
			write_reg(REG_DISTANCE, pick_reg(1));
			write_reg(REG_SPEED, pick_reg(1));
			write_reg(REG_ACCEL, pick_reg(1));
			queue_samples(49);
			if (ph == 10) begin
				wait (sample_q.size() < 12);
				hold_off = 1;
				do @(posedge clk);
				while (motion_q.size() != 0 || in_valid);
				hold_off = 0;
			end
			drain();
		end
		$display("covered %0d samples over 35 random plans plus directed corners, %0d results",
			accepted, results);
		if (errors == 0)
			$display("trapezoid_motion_profile_core: match");
		else
			$display("trapezoid_motion_profile_core: mismatch");
		$finish;
	end
endmodule
